FILE: src/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types for the circular doubly linked list unit: command and status
// codes, and the control group that drives the node store.
// ----------------------------------------------------------------------------
package cdll_pkg;

  typedef enum logic [1:0] {
    CMD_FRONT   = 2'd0,
    CMD_MIDDLE  = 2'd1,
    CMD_END     = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Enables for the node store ports
  typedef struct packed {
    logic rd_en;    // read link and value at rd_addr
    logic nxt_we;   // write a forward link
    logic val_we;   // write a node value
  } store_ctl_t;

endpackage

FILE: src/circular_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_unit
// Fixed-capacity circular list with insert-front, insert-middle, insert-end
// and display commands, kept in a node pool of forward links and values.
// ----------------------------------------------------------------------------
// One request is worked at a time; the input stalls until its last result
// has been placed in the output register. Nodes are taken from the pool in
// insertion order. Insert-front and insert-end go through accept (with the
// head link read), two link writes and the result; an insert into an empty
// list goes from accept straight to the result. Insert-middle adds a walk
// from the head, in which every hop along the list, and the final read of
// the link to splice after, is one read of the link memory. Display reads
// the tail's link at accept and then the head, then gives one result per
// cycle while the output is not stalled, as the link memory read feeds the
// next read address. Refused and empty requests go from accept to the
// result. An output stall holds the sequencer in its result states.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_unit
  import cdll_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_item_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  output logic [6:0]         out_element_count,
  output logic               out_last_of_run
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_LINK2,
    S_EMIT,
    S_DISP_HEAD,
    S_DISP_OUT
  } state_t;

  state_t                   state_r;
  cmd_t                     cmd_r;
  status_t                  stat_r;
  logic [IDX_W-1:0]         tail_r;
  logic [IDX_W-1:0]         before_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         steps_r;
  logic [CNT_W-1:0]         idx_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [31:0]       out_value_r;
  logic [6:0]               out_element_count_r;
  logic                     out_last_of_run_r;

  store_ctl_t               ctl;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         nxt_waddr;
  logic [IDX_W-1:0]         nxt_wdata;
  logic [IDX_W-1:0]         rd_next;
  logic signed [VALUE_WIDTH-1:0] rd_value;
  logic signed [VALUE_WIDTH-1:0] val_wdata;

  logic                     in_acc;
  logic                     slot_free;
  logic                     res_load;
  logic                     list_empty;
  logic                     list_full;
  logic                     disp_last;
  logic [IDX_W-1:0]         fresh;
  cmd_t                     in_cmd;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign res_load   = slot_free && (state_r == S_EMIT || state_r == S_DISP_OUT);
  assign list_empty = (cnt_r == '0);
  assign list_full  = (cnt_r == CNT_W'(CAPACITY));
  assign disp_last  = (idx_r == CNT_W'(cnt_r - CNT_W'(1)));
  assign fresh      = cnt_r[IDX_W-1:0];
  assign in_cmd     = cmd_t'(in_command);
  assign val_wdata  = VALUE_WIDTH'(in_item_value);

  // Node pool
  cdll_node_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W),
    .VW    (VALUE_WIDTH)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .val_waddr (fresh),
    .val_wdata (val_wdata),
    .rd_next   (rd_next),
    .rd_value  (rd_value)
  );

  // Drive the store ports from the sequencer state
  always_comb begin
    ctl       = '0;
    rd_addr   = rd_next;
    nxt_waddr = fresh;
    nxt_wdata = rd_next;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_DISPLAY) begin
            if (!list_empty) begin
              ctl.rd_en = 1'b1;
              rd_addr   = tail_r;
            end
          end else if (!list_full) begin
            ctl.val_we = 1'b1;
            if (list_empty) begin
              ctl.nxt_we = 1'b1;
              nxt_wdata  = fresh;
            end else begin
              ctl.rd_en = 1'b1;
              rd_addr   = tail_r;
            end
          end
        end
      end
      S_WALK: begin
        ctl.rd_en = 1'b1;
      end
      S_LINK: begin
        ctl.nxt_we = 1'b1;
      end
      S_LINK2: begin
        ctl.nxt_we = 1'b1;
        nxt_waddr  = before_r;
        nxt_wdata  = fresh;
      end
      S_DISP_HEAD: begin
        ctl.rd_en = 1'b1;
      end
      S_DISP_OUT: begin
        ctl.rd_en = slot_free && !disp_last;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      tail_r      <= '0;
    end else begin
      // drop a result once it is taken, unless a new one is loaded
      if (out_valid_r && !out_stall && !res_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_cmd;
            if (in_cmd == CMD_DISPLAY) begin
              if (list_empty) begin
                stat_r  <= ST_EMPTY;
                state_r <= S_EMIT;
              end else begin
                idx_r   <= '0;
                state_r <= S_DISP_HEAD;
              end
            end else if (list_full) begin
              stat_r  <= ST_FULL;
              state_r <= S_EMIT;
            end else if (list_empty) begin
              tail_r  <= fresh;
              cnt_r   <= cnt_r + CNT_W'(1);
              stat_r  <= ST_OK;
              state_r <= S_EMIT;
            end else if (in_cmd == CMD_MIDDLE && cnt_r != CNT_W'(1)) begin
              steps_r <= (cnt_r - CNT_W'(1)) >> 1;
              state_r <= S_WALK;
            end else begin
              before_r <= tail_r;
              state_r  <= S_LINK;
            end
          end
        end
        // advance one node per cycle from the head
        S_WALK: begin
          if (steps_r == '0) begin
            before_r <= rd_next;
            state_r  <= S_LINK;
          end else begin
            steps_r <= steps_r - CNT_W'(1);
          end
        end
        S_LINK: begin
          state_r <= S_LINK2;
        end
        S_LINK2: begin
          if (cmd_r == CMD_END) begin
            tail_r <= fresh;
          end
          cnt_r   <= cnt_r + CNT_W'(1);
          stat_r  <= ST_OK;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r         <= 1'b1;
            out_status_r        <= stat_r;
            out_value_r         <= '0;
            out_element_count_r <= 7'(cnt_r);
            out_last_of_run_r   <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        S_DISP_HEAD: begin
          state_r <= S_DISP_OUT;
        end
        // emit one element per free output slot
        S_DISP_OUT: begin
          if (slot_free) begin
            out_valid_r         <= 1'b1;
            out_status_r        <= ST_OK;
            out_value_r         <= 32'(rd_value);
            out_element_count_r <= 7'(cnt_r);
            out_last_of_run_r   <= disp_last;
            idx_r               <= idx_r + CNT_W'(1);
            if (disp_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_value         = out_value_r;
  assign out_element_count = out_element_count_r;
  assign out_last_of_run   = out_last_of_run_r;

  // Pool occupancy never exceeds its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("node count beyond capacity");

  // Occupancy only ever grows by one node
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("node count changed by more than one");

  // Display walk stays within the list
  a_disp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP_OUT |-> idx_r < cnt_r)
    else $error("display walked past the tail");

endmodule

FILE: src/cdll_node_store.sv
// ----------------------------------------------------------------------------
// cdll_node_store
// Node pool: forward links and node values in two synchronous memories with
// one write port each, a shared read address and registered read outputs.
// ----------------------------------------------------------------------------
module cdll_node_store
  import cdll_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int VW    = 32
) (
  input  logic                 clk,
  input  store_ctl_t           ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     nxt_waddr,
  input  logic [IDX_W-1:0]     nxt_wdata,
  input  logic [IDX_W-1:0]     val_waddr,
  input  logic signed [VW-1:0] val_wdata,
  output logic [IDX_W-1:0]     rd_next,
  output logic signed [VW-1:0] rd_value
);

  logic [IDX_W-1:0]     next_mem [DEPTH];
  logic signed [VW-1:0] val_mem  [DEPTH];

  // Forward links: the controller never reads and writes this memory in
  // the same cycle, so no bypass is needed
  always_ff @(posedge clk) begin
    if (ctl.nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    if (ctl.rd_en) begin
      rd_next <= next_mem[rd_addr];
    end
  end

  // Node values: the slot being written is never the one being read
  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (ctl.rd_en) begin
      rd_value <= val_mem[rd_addr];
    end
  end

endmodule

FILE: tb/circular_doubly_linked_list_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_unit_test
// Self-checking bench for the circular list unit. Requests are driven through
// the valid/stall channel and each accepted request updates a queue-based
// copy of the list in head-to-tail order, which yields the results that are
// due. Returned results are checked field by field, in order. The run covers
// the empty list, single-element middle inserts, value extremes, a full pool
// with refused inserts, and full-length displays. Both sides idle at random.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_unit_test
  import cdll_pkg::*;
();

  localparam int POOL_SIZE = 64;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [6:0]         count;
    logic               last;
  } list_result_t;

  // Mirror of the list contents plus the queue of results still owed
  class list_scoreboard;
    int                 held_values[$];
    list_result_t       due_results[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Update the list copy for one accepted request and queue its results
    function void note_request(cmd_t cmd, logic signed [31:0] value);
      list_result_t r;
      int           n;
      n = held_values.size();
      r.value = '0;
      r.last  = 1'b1;
      if (cmd == CMD_DISPLAY) begin
        if (n == 0) begin
          r.status = ST_EMPTY;
          r.count  = '0;
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.status = ST_OK;
            r.value  = held_values[i];
            r.count  = 7'(n);
            r.last   = (i == n - 1);
            due_results.push_back(r);
          end
        end
        return;
      end
      if (n >= POOL_SIZE) begin
        r.status = ST_FULL;
        r.count  = 7'(n);
        due_results.push_back(r);
        return;
      end
      // Place the value in list order; middle with one element means front
      if (n == 0 || cmd == CMD_END)
        held_values.push_back(value);
      else if (cmd == CMD_FRONT || n == 1)
        held_values.push_front(value);
      else
        held_values.insert((n - 1) / 2 + 1, value);
      r.status = ST_OK;
      r.count  = 7'(n + 1);
      due_results.push_back(r);
    endfunction

    // Compare one returned result with the oldest one owed
    function void check_result(logic [1:0] status, logic signed [31:0] value,
                               logic [6:0] count, logic last);
      list_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d count %0d last %0d",
               status, value, count, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (count !== want.count) begin
        $error("element_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = 2'd0;
  logic signed [31:0] in_item_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_value;
  logic [6:0]         out_element_count;
  logic               out_last_of_run;

  bit                 calm = 1'b0;
  list_scoreboard     lists;

  circular_doubly_linked_list_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_value         (out_value),
    .out_element_count (out_element_count),
    .out_last_of_run   (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Stall the result side now and then, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Check every result taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      lists.check_result(out_status, out_value, out_element_count, out_last_of_run);
  end

  // Drive one request, with an optional gap before it, and hold until taken
  task automatic issue_request(cmd_t cmd, logic signed [31:0] value);
    int gap;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_item_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lists.note_request(cmd, value);
  endtask

  initial begin
    cmd_t               cmd;
    logic signed [31:0] value;
    lists = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty display, middle into empty and single lists, extremes
    issue_request(CMD_DISPLAY, 32'sd0);
    issue_request(CMD_MIDDLE, 32'sd5);
    issue_request(CMD_DISPLAY, -32'sd1);
    issue_request(CMD_MIDDLE, 32'sh7fffffff);
    issue_request(CMD_FRONT, 32'sh80000000);
    issue_request(CMD_END, -32'sd1);
    issue_request(CMD_MIDDLE, 32'sd0);
    issue_request(CMD_MIDDLE, 32'sh55555555);
    issue_request(CMD_FRONT, 32'shaaaaaaaa);
    issue_request(CMD_END, 32'sd1);
    issue_request(CMD_DISPLAY, 32'sh7fffffff);
    issue_request(CMD_MIDDLE, 32'sh12345678);
    issue_request(CMD_DISPLAY, 32'sh80000000);

    // Random: grow the list to full, then refused inserts and full displays
    for (int k = 0; k < 230; k++) begin
      calm = (k >= 60 && k < 110);
      if ($urandom_range(0, 99) < 25)
        cmd = CMD_DISPLAY;
      else
        cmd = cmd_t'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0:       value = 32'sh80000000;
        1:       value = 32'sh7fffffff;
        2:       value = 32'sd0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase
      issue_request(cmd, value);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain outstanding results, then allow a little settling time
    while (lists.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lists.errors == 0)
      $display("circular_doubly_linked_list_unit_test passed");
    else
      $display("circular_doubly_linked_list_unit_test failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("circular_doubly_linked_list_unit_test failed");
    $finish;
  end

endmodule
